/* src/mwlfo_pkg.sv */
// shared types and constants of the multi-wave lfo
package mwlfo_pkg;

  localparam int unsigned PhaseW = 32;
  localparam int unsigned LenW   = 9;
  localparam int unsigned SampW  = 16;

  localparam logic [PhaseW-1:0] RngSeed   = 32'd2463534242;
  localparam logic [PhaseW-1:0] PhaseHalf = 32'h8000_0000;
  localparam logic [SampW-1:0]  SampMax   = 16'h7fff;
  localparam logic [SampW-1:0]  SampMin   = 16'h8000;

  typedef enum logic [0:0] {
    CfgPhaseInc  = 1'b0,
    CfgNoteTrig  = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KindRender = 1'b0,
    KindNoteOn = 1'b1
  } item_kind_e;

  // control from the pipeline to the state block
  typedef struct packed {
    logic             fire;
    item_kind_e       kind;
    logic [LenW-1:0]  len;
  } step_t;

  typedef struct packed {
    logic signed [SampW-1:0] triangle;
    logic signed [SampW-1:0] saw;
    logic signed [SampW-1:0] rev_saw;
    logic signed [SampW-1:0] square;
  } waves_t;

  // one xorshift32 step
  function automatic logic [PhaseW-1:0] xorshift32(input logic [PhaseW-1:0] x_in);
    logic [PhaseW-1:0] x;
    x = x_in;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

/* src/mwlfo_wave.sv */
// waveform shaping from the current phase
module mwlfo_wave (
  input  logic [mwlfo_pkg::PhaseW-1:0] phase_i,
  output mwlfo_pkg::waves_t            waves_o
);
  import mwlfo_pkg::*;

  logic [PhaseW-1:0] span;

  always_comb begin
    span = (phase_i >= PhaseHalf) ? (phase_i - PhaseHalf) : (PhaseHalf - phase_i);

    // distance of a full half cycle only at phase zero
    if (span[31]) begin
      waves_o.triangle = SampMax;
    end else begin
      waves_o.triangle = {~span[30], span[29:15]};
    end

    waves_o.saw = {~phase_i[31], phase_i[30:16]};

    if (phase_i[31:16] == '0) begin
      waves_o.rev_saw = SampMax;
    end else begin
      waves_o.rev_saw = SampMin - phase_i[31:16];
    end

    waves_o.square = (phase_i > PhaseHalf) ? SampMin : SampMax;
  end

endmodule

/* src/mwlfo_state.sv */
// phase accumulator, last phase and sample-and-hold state
module mwlfo_state (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mwlfo_pkg::step_t              step_i,
  input  logic [mwlfo_pkg::PhaseW-1:0]  phase_inc_i,
  input  logic                          note_trig_i,
  output logic [mwlfo_pkg::PhaseW-1:0]  phase_o,
  output logic [mwlfo_pkg::SampW-1:0]   hold_o
);
  import mwlfo_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PhaseW-1:0] last_q, last_d;
  logic [SampW-1:0]  held_q, held_d;
  logic [PhaseW-1:0] rng_q, rng_d;
  logic [PhaseW-1:0] rng_next;
  logic [PhaseW-1:0] advance;
  logic              wrapped;

  always_comb begin
    rng_next = xorshift32(rng_q);
    advance  = phase_inc_i * {{(PhaseW-LenW){1'b0}}, step_i.len};
    wrapped  = phase_q < last_q;

    phase_d = phase_q;
    last_d  = last_q;
    held_d  = held_q;
    rng_d   = rng_q;

    if (step_i.fire) begin
      if (step_i.kind == KindNoteOn) begin
        if (note_trig_i) begin
          phase_d = '0;
        end
      end else begin
        if (wrapped) begin
          rng_d  = rng_next;
          held_d = {~rng_next[31], rng_next[30:16]};
        end
        last_d  = phase_q;
        phase_d = phase_q + advance;
      end
    end
  end

  assign phase_o = phase_q;
  assign hold_o  = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      last_q  <= '0;
      held_q  <= '0;
      rng_q   <= RngSeed;
    end else begin
      phase_q <= phase_d;
      last_q  <= last_d;
      held_q  <= held_d;
      rng_q   <= rng_d;
    end
  end

endmodule

/* src/multi_wave_lfo_top.sv */
// top level of the multi-wave lfo: input register, shaping logic, result register
// One item enters an input register; when it moves on, the shaping logic turns the
// current phase into the four waveforms, the sample-and-hold and phase state are
// updated, and the result lands in an output register. Items are taken one per
// cycle: the input register moves on whenever the output register is empty or is
// being emptied. A stalled result holds a render item waiting in the input register,
// and that stalls the input until the result is taken. A result is registered as
// its item leaves the input register. A render item (kind 0) gives one result;
// a note-on item (kind 1) gives none and only clears the phase in note trigger
// mode. Configuration writes are taken at any cycle and should be made while idle.
module multi_wave_lfo_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_index_i,
  input  logic [mwlfo_pkg::PhaseW-1:0]        cfg_data_i,
  // item input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [mwlfo_pkg::LenW-1:0]          block_len_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mwlfo_pkg::SampW-1:0]  triangle_out_o,
  output logic signed [mwlfo_pkg::SampW-1:0]  saw_out_o,
  output logic signed [mwlfo_pkg::SampW-1:0]  reverse_saw_out_o,
  output logic signed [mwlfo_pkg::SampW-1:0]  square_out_o,
  output logic signed [mwlfo_pkg::SampW-1:0]  hold_out_o
);
  import mwlfo_pkg::*;

  // configuration registers
  logic [PhaseW-1:0] phase_inc_q;
  logic              note_trig_q;

  // input register
  logic              s1_valid_q;
  item_kind_e        s1_kind_q;
  logic [LenW-1:0]   s1_len_q;

  // output register
  logic              out_valid_q;
  waves_t            waves_q;
  logic [SampW-1:0]  hold_q;

  logic              out_free;
  logic              s1_move;
  logic              in_take;
  step_t             step;
  waves_t            waves;
  logic [PhaseW-1:0] phase;
  logic [SampW-1:0]  hold_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= '0;
      note_trig_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPhaseInc: phase_inc_q <= cfg_data_i;
        CfgNoteTrig: note_trig_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // output slot can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // a note-on never needs the output slot
  assign s1_move = s1_valid_q && ((s1_kind_q == KindNoteOn) || out_free);

  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q <= item_kind_e'(kind_i);
      s1_len_q  <= block_len_i;
    end
  end

  assign step.fire = s1_move;
  assign step.kind = s1_kind_q;
  assign step.len  = s1_len_q;

  mwlfo_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .phase_inc_i (phase_inc_q),
    .note_trig_i (note_trig_q),
    .phase_o     (phase),
    .hold_o      (hold_val)
  );

  // waveforms come from the phase before this item's advance
  mwlfo_wave u_wave (
    .phase_i (phase),
    .waves_o (waves)
  );

  // result register: loaded by a render, emptied when taken downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move && (s1_kind_q == KindRender)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && (s1_kind_q == KindRender)) begin
      waves_q <= waves;
      hold_q  <= hold_val;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign triangle_out_o    = waves_q.triangle;
  assign saw_out_o         = waves_q.saw;
  assign reverse_saw_out_o = waves_q.rev_saw;
  assign square_out_o      = waves_q.square;
  assign hold_out_o        = hold_q;

endmodule
